/* hdl/slje_pkg.sv */
// ----------------------------------------------------------------------------
// slje_pkg
// Shared types and constants for the shifted Lennard-Jones energy unit:
// register indexes, reset values, pipeline depth and the per-stage tag.
// ----------------------------------------------------------------------------
package slje_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_CUTOFF_SQ    = 2'd0,
		REG_ENERGY_SHIFT = 2'd1
	} slje_reg_t;

	// register reset values
	localparam logic [31:0]        SLJE_CUTOFF_RST = 32'd104857600;  // 6.25 in Q8.24
	localparam logic signed [14:0] SLJE_SHIFT_RST  = -15'sd267;

	// 1/x is formed by a restoring divider, one quotient bit per stage
	localparam int SLJE_DIV_STAGES = 30;
	// accept edge to the edge that takes the result
	localparam int SLJE_LATENCY    = SLJE_DIV_STAGES + 6;

	// output limits, Q16.16
	localparam logic [31:0] SLJE_E_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SLJE_E_MIN = 32'h8000_0000;

	// control that travels with each item
	typedef struct packed {
		logic valid;   // stage holds an item
		logic beyond;  // distance beyond cutoff, energy forced to zero
		logic sat_hi;  // pair too close, energy forced to the positive limit
	} slje_tag_t;

endpackage

/* hdl/shifted_lennard_jones_energy_unit.sv */
// ----------------------------------------------------------------------------
// shifted_lennard_jones_energy_unit
// Truncated, shifted Lennard-Jones 12-6 pair energy, fully pipelined.
// ----------------------------------------------------------------------------
// One squared distance (unsigned Q8.24) is taken per clock whenever start is
// high; busy never rises. Each item gives one result, energy (signed Q16.16)
// and saturated, shown for one cycle with done high, in input order. There is
// no backpressure: the receiver must take every result in its done cycle.
// The depth is set by the 30-stage restoring divider that forms 1/rsq one
// quotient bit per stage, followed by three multiplier stages, one add stage
// and the output register. Registers cutoff_sq and energy_shift are written
// through the cfg channel, which is always ready; write them only while no
// item is in flight.
// ----------------------------------------------------------------------------
module shifted_lennard_jones_energy_unit
	import slje_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// item channel
	input  logic        start,
	output logic        busy,
	input  logic [31:0] dist_sq,

	// result channel
	output logic        done,
	output logic [31:0] energy,
	output logic        saturated,

	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int ND = SLJE_DIV_STAGES;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [31:0]        cutoff_sq_q;
	logic signed [14:0] energy_shift_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_sq_q    <= SLJE_CUTOFF_RST;
			energy_shift_q <= SLJE_SHIFT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CUTOFF_SQ:    cutoff_sq_q    <= cfg_data;
				REG_ENERGY_SHIFT: energy_shift_q <= $signed(cfg_data[14:0]);
				default:          ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// divider pipeline: element 0 is the entry stage, element k holds the
	// item after k quotient bits. 2^50 / x with x >= 2^21 has its top 21
	// dividend bits below x, so the partial remainder starts at 2^20.
	// ------------------------------------------------------------------
	slje_tag_t   div_tag_s [0:ND];
	logic [31:0] div_x_s   [0:ND];
	logic [31:0] div_rem_s [0:ND];
	logic [ND-1:0] div_quo_s [0:ND];

	slje_tag_t entry_tag;

	always_comb begin
		entry_tag.valid  = start && !busy;
		entry_tag.beyond = dist_sq > cutoff_sq_q;
		entry_tag.sat_hi = ~|dist_sq[31:21];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_tag_s[0] <= '0;
		end else begin
			div_tag_s[0] <= entry_tag;
		end
	end

	always_ff @(posedge clk) begin
		div_x_s[0]   <= dist_sq;
		div_rem_s[0] <= 32'd1 << 20;
		div_quo_s[0] <= '0;
	end

	for (genvar k = 1; k <= ND; k++) begin : g_div
		logic [32:0] rem_sh;
		logic [33:0] diff;

		// shift in a zero dividend bit, trial subtract
		always_comb begin
			rem_sh = {div_rem_s[k-1], 1'b0};
			diff   = {1'b0, rem_sh} - {2'b00, div_x_s[k-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_tag_s[k] <= '0;
			end else begin
				div_tag_s[k] <= div_tag_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			div_x_s[k] <= div_x_s[k-1];
			if (!diff[33]) begin
				div_rem_s[k] <= diff[31:0];
				div_quo_s[k] <= {div_quo_s[k-1][ND-2:0], 1'b1};
			end else begin
				div_rem_s[k] <= rem_sh[31:0];
				div_quo_s[k] <= {div_quo_s[k-1][ND-2:0], 1'b0};
			end
		end
	end

	// ------------------------------------------------------------------
	// p = q*q >> 26  (1/x^2, Q.26)
	// ------------------------------------------------------------------
	logic [59:0] pq_prod;
	slje_tag_t   tag_s32;
	logic [32:0] p_s32;
	logic [29:0] q_s32;

	assign pq_prod = 60'(div_quo_s[ND]) * 60'(div_quo_s[ND]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s32 <= '0;
		end else begin
			tag_s32 <= div_tag_s[ND];
		end
	end

	always_ff @(posedge clk) begin
		p_s32 <= pq_prod[58:26];
		q_s32 <= div_quo_s[ND];
	end

	// ------------------------------------------------------------------
	// v = p*q >> 26, w = v >> 2 (u in Q.24); u >= 128 saturates high
	// ------------------------------------------------------------------
	logic [62:0] v_prod;
	logic [33:0] w_full;
	slje_tag_t   tag_s33;
	logic [30:0] w_s33;

	always_comb begin
		v_prod = 63'(p_s32) * 63'(q_s32);
		w_full = v_prod[61:28];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s33 <= '0;
		end else begin
			tag_s33 <= {tag_s32.valid, tag_s32.beyond,
				tag_s32.sat_hi | (|w_full[33:31])};
		end
	end

	always_ff @(posedge clk) begin
		w_s33 <= w_full[30:0];
	end

	// ------------------------------------------------------------------
	// w*w  (u^2 in Q.48)
	// ------------------------------------------------------------------
	slje_tag_t   tag_s34;
	logic [61:0] ww_s34;
	logic [30:0] w_s34;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s34 <= '0;
		end else begin
			tag_s34 <= tag_s33;
		end
	end

	always_ff @(posedge clk) begin
		ww_s34 <= 62'(w_s33) * 62'(w_s33);
		w_s34  <= w_s33;
	end

	// ------------------------------------------------------------------
	// r = round(4*(u^2 - u) to Q16.16), biased by +4 so it stays unsigned
	// ------------------------------------------------------------------
	logic [62:0] m_sum;
	slje_tag_t   tag_s35;
	logic [32:0] r_s35;

	assign m_sum = 63'(ww_s34) + (63'd1 << 48) + (63'd1 << 29) - (63'(w_s34) << 24);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s35 <= '0;
		end else begin
			tag_s35 <= tag_s34;
		end
	end

	always_ff @(posedge clk) begin
		r_s35 <= m_sum[62:30];
	end

	// ------------------------------------------------------------------
	// remove bias and shift, clamp, apply special cases
	// ------------------------------------------------------------------
	logic signed [34:0] shift4;
	logic signed [34:0] e_full;
	logic [31:0]        e_out;
	logic               sat_out;
	logic [31:0]        energy_s36;
	logic               sat_s36;
	logic               done_s36;

	always_comb begin
		shift4 = $signed({{18{energy_shift_q[14]}}, energy_shift_q, 2'b00});
		e_full = $signed({2'b00, r_s35}) - 35'sd262144 - shift4;
		if (tag_s35.beyond) begin
			e_out   = '0;
			sat_out = 1'b0;
		end else if (tag_s35.sat_hi) begin
			e_out   = SLJE_E_MAX;
			sat_out = 1'b1;
		end else if (e_full > 35'sd2147483647) begin
			e_out   = SLJE_E_MAX;
			sat_out = 1'b1;
		end else if (e_full < -35'sd2147483648) begin
			e_out   = SLJE_E_MIN;
			sat_out = 1'b1;
		end else begin
			e_out   = e_full[31:0];
			sat_out = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s36 <= 1'b0;
		end else begin
			done_s36 <= tag_s35.valid;
		end
	end

	always_ff @(posedge clk) begin
		energy_s36 <= e_out;
		sat_s36    <= sat_out;
	end

	assign done      = done_s36;
	assign energy    = energy_s36;
	assign saturated = sat_s36;

endmodule

/* hdl/slje_checker.sv */
// ----------------------------------------------------------------------------
// slje_checker
// Port-level checks for the shifted Lennard-Jones energy unit, bound to it.
// ----------------------------------------------------------------------------
module slje_checker
	import slje_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] dist_sq,
	input logic        done,
	input logic [31:0] energy,
	input logic        saturated
);

	localparam int AGE_W = $clog2(SLJE_LATENCY + 1);

	// cycles since reset, saturating at the pipeline depth
	logic [AGE_W-1:0] age_q;
	logic             settled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_q != AGE_W'(SLJE_LATENCY)) begin
			age_q <= age_q + 1'b1;
		end
	end

	assign settled = age_q == AGE_W'(SLJE_LATENCY);

	// one result per transfer, at fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		settled |-> (done == $past(start && !busy, SLJE_LATENCY)))
		else $error("result strobe does not match accepted item");

	// a flagged result sits on a limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (energy == SLJE_E_MAX || energy == SLJE_E_MIN))
		else $error("saturated result not at a limit");

	// zero distance is always inside the cutoff and saturates high
	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(settled && done && $past(start && !busy && dist_sq == 32'd0, SLJE_LATENCY))
		|-> (saturated && energy == SLJE_E_MAX))
		else $error("zero distance did not saturate high");

	// the well bottom and shift keep unflagged results well above the low limit
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !saturated) |-> (!energy[31] || energy[31:20] == 12'hFFF))
		else $error("unflagged energy below the attainable floor");

endmodule

bind shifted_lennard_jones_energy_unit slje_checker u_slje_checker (.*);

/* test/shifted_lennard_jones_energy_unit_test.sv */
// ----------------------------------------------------------------------------
// shifted_lennard_jones_energy_unit_test
// Self-checking bench for the shifted Lennard-Jones energy unit. A scoreboard
// predicts energy and saturation for every accepted squared distance in fixed
// point. Results are checked in order. Stimulus runs through several cutoff
// and shift settings, including the extremes and writes to unused indexes.
// Random bursts of distances cover the zero, close-pair, saturation-edge,
// well, cutoff-edge and beyond-cutoff regions.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module shifted_lennard_jones_energy_unit_test;
	import slje_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam logic [1:0]  REG_SPARE_A = 2'd2;
	localparam logic [1:0]  REG_SPARE_B = 2'd3;
	localparam logic [31:0] CLOSE_LIMIT = 32'h0020_0000;   // 2^21, u = 512
	localparam logic [31:0] ONE_Q824    = 32'h0100_0000;

	typedef struct {
		logic [31:0] energy;
		logic        saturated;
	} energy_rec_t;

	// scoreboard: mirrors the two registers, predicts and checks results
	class energy_board;
		logic [31:0]        cutoff;
		logic signed [14:0] shift;
		energy_rec_t        due[$];
		int errors, n_in, n_out, n_sat, n_beyond, n_writes;

		function new();
			cutoff = SLJE_CUTOFF_RST;
			shift  = SLJE_SHIFT_RST;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			n_writes++;
			case (slje_reg_t'(idx))
				REG_CUTOFF_SQ: begin
					cutoff = data;
				end
				REG_ENERGY_SHIFT: begin
					shift = data[14:0];
				end
				default: begin
				end
			endcase
		endfunction

		// truncated shifted LJ energy in Q16.16, reciprocal chain in Q.26
		function energy_rec_t lj_energy(logic [31:0] x);
			energy_rec_t     r;
			longint unsigned q, p, v, w, m, rr;
			longint          e;
			r.energy    = 32'd0;
			r.saturated = 1'b0;
			if (x > cutoff) begin
				n_beyond++;
			end else if (x < CLOSE_LIMIT) begin
				r.energy    = SLJE_E_MAX;
				r.saturated = 1'b1;
			end else begin
				q = (64'd1 << 50) / {32'd0, x};
				p = (q * q) >> 26;
				v = (p * q) >> 26;
				w = v >> 2;
				if (w >= (64'd1 << 31)) begin
					r.energy    = SLJE_E_MAX;
					r.saturated = 1'b1;
				end else begin
					// offset by 2^48 keeps u^2 - u non-negative
					m  = w * w + (64'd1 << 48) - (w << 24);
					rr = (m + (64'd1 << 29)) >> 30;
					e  = longint'(rr) - (64'sd1 <<< 18) - 4 * longint'(shift);
					if (e > 64'sd2147483647) begin
						r.energy    = SLJE_E_MAX;
						r.saturated = 1'b1;
					end else if (e < -64'sd2147483648) begin
						r.energy    = SLJE_E_MIN;
						r.saturated = 1'b1;
					end else begin
						r.energy = e[31:0];
					end
				end
			end
			return r;
		endfunction

		function void note_input(logic [31:0] x);
			energy_rec_t r;
			r = lj_energy(x);
			n_in++;
			if (r.saturated)
				n_sat++;
			due.push_back(r);
		endfunction

		function void check_result(logic [31:0] energy, logic saturated);
			energy_rec_t r;
			n_out++;
			if (due.size() == 0) begin
				$error("result with nothing pending: energy %h saturated %b",
					energy, saturated);
				errors++;
				return;
			end
			r = due.pop_front();
			if (energy !== r.energy) begin
				$error("energy: expected %h, got %h", r.energy, energy);
				errors++;
			end
			if (saturated !== r.saturated) begin
				$error("saturated: expected %b, got %b", r.saturated, saturated);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	logic [31:0] dist_sq   = 32'd0;
	logic        done;
	logic [31:0] energy;
	logic        saturated;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [31:0] cfg_data  = 32'd0;

	energy_board board = new();
	int          cycles = 0;

	shifted_lennard_jones_energy_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.dist_sq   (dist_sq),
		.done      (done),
		.energy    (energy),
		.saturated (saturated),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// observe transfers on all three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_input(dist_sq);
			if (done)
				board.check_result(energy, saturated);
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("shifted_lennard_jones_energy_unit_test failed");
			$finish;
		end
	end

	// one distance transfer; start stays high for a following item
	task automatic send_dist(input logic [31:0] x);
		start   <= 1'b1;
		dist_sq <= x;
		do @(posedge clk); while (busy);
	endtask

	// register write; caller drops cfg_valid after the last one
	task automatic set_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// hold off until every pending result is back
	task automatic drain();
		start <= 1'b0;
		while (board.due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// weighted choice of distance region
	function automatic logic [31:0] pick_dist();
		int          sel;
		logic [31:0] c;
		sel = $urandom_range(0, 99);
		c   = board.cutoff;
		if (sel < 10)
			return $urandom();
		else if (sel < 15)
			return ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, CLOSE_LIMIT - 1);
		else if (sel < 30)
			return $urandom_range(3000000, 5000000);       // positive saturation edge
		else if (sel < 70)
			return $urandom_range(CLOSE_LIMIT, 32'h0400_0000);
		else if (sel < 85)
			return (c >= CLOSE_LIMIT) ? $urandom_range(CLOSE_LIMIT, c) : $urandom();
		else if (sel < 95)
			return c + $urandom_range(0, 8) - 32'd4;       // around the cutoff
		else
			return $urandom_range(32'h0400_0000, 32'hFFFF_FFFF);
	endfunction

	// random bursts with random gaps, zero gaps included
	task automatic run_random(input int n_items);
		int left;
		int burst;
		int gap;
		left = n_items;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && left > 0) begin
				send_dist(pick_dist());
				burst--;
				left--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start   <= 1'b0;
				dist_sq <= $urandom();
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic run_directed();
		logic [31:0] c;
		c = board.cutoff;
		send_dist(32'd0);
		send_dist(32'd1);
		send_dist(CLOSE_LIMIT - 1);
		send_dist(CLOSE_LIMIT);
		send_dist(CLOSE_LIMIT + 1);
		send_dist(32'd3500000);
		send_dist(32'd3735000);
		send_dist(32'd3740000);
		send_dist(32'd4000000);
		send_dist(ONE_Q824);             // r = 1, energy is -4*shift
		send_dist(32'd21137999);         // near the potential minimum
		send_dist(32'd25000000);
		start <= 1'b0;
		repeat (3) @(posedge clk);
		send_dist(c - 1);
		send_dist(c);
		send_dist(c + 1);
		send_dist(32'h7FFF_FFFF);
		send_dist(32'h8000_0000);
		send_dist(32'hAAAA_AAAA);
		send_dist(32'h5555_5555);
		send_dist(32'hFFFF_FFFF);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		run_directed();
		run_random(250);
		drain();

		// widest cutoff, zero shift
		set_reg(REG_CUTOFF_SQ, 32'hFFFF_FFFF);
		set_reg(REG_ENERGY_SHIFT, {17'($urandom_range(0, 32'h1_FFFF)), 15'h0000});
		cfg_valid <= 1'b0;
		send_dist(32'hFFFF_FFFF);
		send_dist(32'h0000_0000);
		run_random(300);
		drain();

		// zero cutoff, most negative shift
		set_reg(REG_CUTOFF_SQ, 32'd0);
		set_reg(REG_ENERGY_SHIFT, 32'h0000_4000);
		cfg_valid <= 1'b0;
		send_dist(32'd0);
		send_dist(32'd1);
		run_random(200);
		drain();

		// mid cutoff, largest positive shift pattern; unused indexes do nothing
		set_reg(REG_CUTOFF_SQ, $urandom_range(32'h0100_0000, 32'h1000_0000));
		set_reg(REG_ENERGY_SHIFT, 32'h0000_3FFF);
		set_reg(REG_SPARE_A, $urandom());
		set_reg(REG_SPARE_B, $urandom());
		cfg_valid <= 1'b0;
		send_dist(ONE_Q824);
		run_random(300);
		drain();

		// cutoff at the close-pair limit, shift -1
		set_reg(REG_CUTOFF_SQ, CLOSE_LIMIT);
		set_reg(REG_ENERGY_SHIFT, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		send_dist(CLOSE_LIMIT);
		send_dist(CLOSE_LIMIT + 1);
		run_random(250);
		drain();

		// back to reset values
		set_reg(REG_CUTOFF_SQ, SLJE_CUTOFF_RST);
		set_reg(REG_ENERGY_SHIFT, {17'd0, SLJE_SHIFT_RST});
		cfg_valid <= 1'b0;
		run_random(300);
		drain();

		// fully random settings
		set_reg(REG_ENERGY_SHIFT, $urandom());
		set_reg(REG_CUTOFF_SQ, $urandom());
		cfg_valid <= 1'b0;
		run_random(325);
		drain();

		repeat (SLJE_LATENCY + 4) @(posedge clk);

		$display("covered %0d distances, %0d results, %0d saturated, %0d beyond cutoff",
			board.n_in, board.n_out, board.n_sat, board.n_beyond);
		$display("seven register settings, %0d register writes, %0d cycles",
			board.n_writes, cycles);
		if (board.errors == 0 && board.due.size() == 0) begin
			$display("shifted_lennard_jones_energy_unit_test passed");
		end else begin
			$display("shifted_lennard_jones_energy_unit_test failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/slje_pkg.sv
hdl/shifted_lennard_jones_energy_unit.sv
hdl/slje_checker.sv
test/shifted_lennard_jones_energy_unit_test.sv
